// File: rtl/spsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsd_pkg
// Shared types and constants of the subtitle PES segment deframer.
// ----------------------------------------------------------------------------
package spsd_pkg;

   localparam logic [7:0] STREAM_ID_PRIVATE = 8'hBD;
   localparam logic [7:0] DATA_IDENTIFIER   = 8'h20;
   localparam logic [7:0] SEGMENT_SYNC      = 8'h0F;
   localparam logic [7:0] START_CODE_LAST   = 8'h01;
   localparam logic [7:0] END_MARKER        = 8'hFF;
   localparam int unsigned SEG_FIELD_BYTES  = 2 * 2 + 1;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   localparam logic [2:0] ST_END_MARKER  = 3'd0;
   localparam logic [2:0] ST_NO_MARKER   = 3'd1;
   localparam logic [2:0] ST_NOT_SUBT    = 3'd2;
   localparam logic [2:0] ST_LENGTH      = 3'd3;
   localparam logic [2:0] ST_BAD_MARKER  = 3'd4;
   localparam logic [2:0] ST_PES_HEADER  = 3'd5;
   localparam logic [2:0] ST_BUFFER_END  = 3'd6;

   localparam int unsigned QUEUE_DEPTH = 4;

   typedef enum logic [3:0] {
      PH_SYNC0,
      PH_SYNC1,
      PH_SYNC2,
      PH_STREAM,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_FLAGS,
      PH_HLEN,
      PH_HEADER,
      PH_DATA_ID,
      PH_SUBSTREAM,
      PH_MARKER,
      PH_SEG_FIELDS,
      PH_SEG_PAYLOAD,
      PH_SKIP
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  seg_code;
      logic [15:0] page_id;
      logic [15:0] seg_size;
      logic [7:0]  payload_byte;
      logic        segment_end;
      logic [2:0]  status;
      logic        run_last;
   } result_type;

   // up to two result words per input byte
   typedef struct packed {
      logic [1:0] count;
      result_type slot0;
      result_type slot1;
   } result_pair_type;

endpackage

// File: rtl/spsd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsd_parser
// PES and segment framing state; turns one byte into up to two result words.
// ----------------------------------------------------------------------------
module spsd_parser
   import spsd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      data_byte,
   input  logic            buffer_first,
   input  logic            buffer_last,
   output result_pair_type results
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  hc_ff, hc_in;
   logic [15:0] pes_ff, pes_in;
   logic [15:0] pr_ff, pr_in;
   logic [15:0] sr_ff, sr_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] page_ff, page_in;
   logic [15:0] len_ff, len_in;
   logic        drop_ff, drop_in;

   phase_type   cur_phase;
   logic        cur_drop;
   logic [16:0] diff;
   logic        fin;
   logic [2:0]  fin_st;
   logic        ent;
   logic        st1;
   result_pair_type po;

   function automatic result_pair_type push(result_pair_type p, result_type r);
      result_pair_type q;
      q = p;
      if (p.count == 2'd0) begin
         q.slot0 = r;
         q.count = 2'd1;
      end else if (p.count == 2'd1) begin
         q.slot1 = r;
         q.count = 2'd2;
      end
      return q;
   endfunction

   function automatic result_type status_result(logic [2:0] st);
      result_type r;
      r = '0;
      r.kind = KIND_STATUS;
      r.status = st;
      return r;
   endfunction

   function automatic result_type seg_result(logic [1:0] kind, logic [7:0] st,
                                             logic [15:0] pg, logic [15:0] ln,
                                             logic [7:0] pb, logic se);
      result_type r;
      r = '0;
      r.kind = kind;
      r.seg_code = st;
      r.page_id = pg;
      r.seg_size = ln;
      r.payload_byte = pb;
      r.segment_end = se;
      return r;
   endfunction

   always_comb begin
      phase_in = phase_ff;
      hc_in = hc_ff;
      pes_in = pes_ff;
      pr_in = pr_ff;
      sr_in = sr_ff;
      type_in = type_ff;
      page_in = page_ff;
      len_in = len_ff;
      drop_in = drop_ff;
      po = '0;
      fin = 1'b0;
      fin_st = ST_END_MARKER;
      ent = 1'b0;
      st1 = 1'b0;
      diff = {1'b0, pes_ff} - {9'd0, data_byte} - 17'd3;
      cur_phase = buffer_first ? PH_SYNC0 : phase_ff;
      cur_drop = buffer_first ? 1'b0 : drop_ff;
      phase_in = cur_phase;
      drop_in = cur_drop;

      if (!cur_drop) begin
         case (cur_phase)
            PH_SYNC0, PH_SYNC1: begin
               if (data_byte != 8'h00) begin
                  po = push(po, status_result(ST_PES_HEADER));
                  phase_in = PH_SYNC0;
                  drop_in = 1'b1;
               end else begin
                  phase_in = (cur_phase == PH_SYNC0) ? PH_SYNC1 : PH_SYNC2;
               end
            end
            PH_SYNC2: begin
               if (data_byte != START_CODE_LAST) begin
                  po = push(po, status_result(ST_PES_HEADER));
                  phase_in = PH_SYNC0;
                  drop_in = 1'b1;
               end else begin
                  phase_in = PH_STREAM;
               end
            end
            PH_STREAM: begin
               if (data_byte != STREAM_ID_PRIVATE) begin
                  po = push(po, status_result(ST_NOT_SUBT));
                  phase_in = PH_SYNC0;
                  drop_in = 1'b1;
               end else begin
                  phase_in = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               pes_in = {data_byte, 8'h00};
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               pes_in = pes_ff | {8'h00, data_byte};
               hc_in = 8'd0;
               phase_in = PH_FLAGS;
            end
            PH_FLAGS: begin
               hc_in = hc_ff + 8'd1;
               if (hc_in >= 8'd2) begin
                  phase_in = PH_HLEN;
               end
            end
            PH_HLEN: begin
               if (diff[16]) begin
                  po = push(po, status_result(ST_PES_HEADER));
                  phase_in = PH_SYNC0;
                  drop_in = 1'b1;
               end else begin
                  pr_in = diff[15:0];
                  if (data_byte != 8'h00) begin
                     hc_in = data_byte;
                     phase_in = PH_HEADER;
                  end else begin
                     ent = 1'b1;
                  end
               end
            end
            PH_HEADER: begin
               hc_in = hc_ff - 8'd1;
               if (hc_in == 8'd0) begin
                  ent = 1'b1;
               end
            end
            PH_DATA_ID: begin
               pr_in = pr_ff - 16'd1;
               if (data_byte != DATA_IDENTIFIER) begin
                  fin = 1'b1;
                  fin_st = ST_NOT_SUBT;
               end else begin
                  phase_in = PH_SUBSTREAM;
               end
            end
            PH_SUBSTREAM: begin
               pr_in = pr_ff - 16'd1;
               if (data_byte != 8'h00) begin
                  fin = 1'b1;
                  fin_st = ST_NOT_SUBT;
               end else begin
                  phase_in = PH_MARKER;
               end
            end
            PH_MARKER: begin
               pr_in = pr_ff - 16'd1;
               if (data_byte == SEGMENT_SYNC) begin
                  if (pr_in < 16'(SEG_FIELD_BYTES)) begin
                     fin = 1'b1;
                     fin_st = ST_LENGTH;
                  end else begin
                     hc_in = 8'd0;
                     phase_in = PH_SEG_FIELDS;
                  end
               end else begin
                  fin = 1'b1;
                  fin_st = (data_byte == END_MARKER) ? ST_END_MARKER : ST_BAD_MARKER;
               end
            end
            PH_SEG_FIELDS: begin
               pr_in = pr_ff - 16'd1;
               case (hc_ff)
                  8'd0: type_in = data_byte;
                  8'd1: page_in = {data_byte, 8'h00};
                  8'd2: page_in = page_ff | {8'h00, data_byte};
                  8'd3: len_in = {data_byte, 8'h00};
                  default: len_in = len_ff | {8'h00, data_byte};
               endcase
               hc_in = hc_ff + 8'd1;
               if (hc_in >= 8'(SEG_FIELD_BYTES)) begin
                  if (pr_in < len_in) begin
                     fin = 1'b1;
                     fin_st = ST_LENGTH;
                  end else begin
                     po = push(po, seg_result(KIND_HEADER, type_in, page_in, len_in,
                                              8'h00, 1'b0));
                     sr_in = len_in;
                     if (len_in != 16'd0) begin
                        phase_in = PH_SEG_PAYLOAD;
                     end else if (pr_in == 16'd0) begin
                        st1 = 1'b1;
                     end else begin
                        phase_in = PH_MARKER;
                     end
                  end
               end
            end
            PH_SEG_PAYLOAD: begin
               if (pr_ff != 16'd0) begin
                  pr_in = pr_ff - 16'd1;
               end
               if (sr_ff != 16'd0) begin
                  sr_in = sr_ff - 16'd1;
               end
               po = push(po, seg_result(KIND_PAYLOAD, type_ff, page_ff, len_ff,
                                        data_byte, sr_in == 16'd0));
               if (sr_in == 16'd0) begin
                  if (pr_in == 16'd0) begin
                     st1 = 1'b1;
                  end else begin
                     phase_in = PH_MARKER;
                  end
               end
            end
            PH_SKIP: begin
               if (pr_ff != 16'd0) begin
                  pr_in = pr_ff - 16'd1;
               end
               if (pr_in == 16'd0) begin
                  po = push(po, status_result(hc_ff[2:0]));
                  phase_in = PH_SYNC0;
               end
            end
            default: begin
               phase_in = PH_SYNC0;
            end
         endcase

         // payload entry: too short to hold more than data id, substream id and a marker
         if (ent) begin
            if (pr_in <= 16'd3) begin
               fin = 1'b1;
               fin_st = ST_LENGTH;
            end else begin
               phase_in = PH_DATA_ID;
            end
         end

         // outcome known: report now, or skip to the end of the packet
         if (fin) begin
            if (pr_in == 16'd0) begin
               po = push(po, status_result(fin_st));
               phase_in = PH_SYNC0;
            end else begin
               hc_in = {5'd0, fin_st};
               phase_in = PH_SKIP;
            end
         end

         if (st1) begin
            po = push(po, status_result(ST_NO_MARKER));
            phase_in = PH_SYNC0;
         end

         if (buffer_last && !drop_in && phase_in != PH_SYNC0) begin
            po = push(po, status_result(ST_BUFFER_END));
            phase_in = PH_SYNC0;
            drop_in = 1'b1;
         end
      end

      if (po.count == 2'd2) begin
         po.slot1.run_last = 1'b1;
      end else if (po.count == 2'd1) begin
         po.slot0.run_last = 1'b1;
      end
      results = po;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC0;
         hc_ff <= 8'd0;
         pes_ff <= 16'd0;
         pr_ff <= 16'd0;
         sr_ff <= 16'd0;
         type_ff <= 8'd0;
         page_ff <= 16'd0;
         len_ff <= 16'd0;
         drop_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hc_ff <= hc_in;
         pes_ff <= pes_in;
         pr_ff <= pr_in;
         sr_ff <= sr_in;
         type_ff <= type_in;
         page_ff <= page_in;
         len_ff <= len_in;
         drop_ff <= drop_in;
      end
   end

endmodule

// File: rtl/spsd_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsd_result_queue
// Small result queue: takes up to two words per cycle, gives one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module spsd_result_queue
   import spsd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  result_pair_type push_data,
   output logic            has_room,
   output logic            out_valid,
   input  logic            out_ready,
   output result_type      out_data
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   result_type              slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [1:0]              push_n;
   logic                    pop;

   assign push_n = push ? push_data.count : 2'd0;
   assign pop = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_data = slots_ff[rd_ptr_ff];
   assign has_room = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         slots_ff[wr_ptr_ff] <= push_data.slot0;
      end
      if (push_n == 2'd2) begin
         slots_ff[PTR_W'(wr_ptr_ff + PTR_W'(1))] <= push_data.slot1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/subtitle_pes_segment_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtitle_pes_segment_deframer
// Splits a byte stream of subtitle PES packets into segment headers, tagged
// payload bytes and one status word per packet.
// ----------------------------------------------------------------------------
// req_*: one input byte per word; tuser marks the first byte of a buffer,
//   tlast the last one.
// rsp_*: result words; tuser gives the kind (header, payload byte, status),
//   tlast marks the last word caused by one input byte.
// A byte is parsed in the cycle it is taken; its words are written to the
// result queue and reach rsp_* from there. One byte per cycle is sustained
// while the queue has room. A byte that causes two words (header or payload
// plus status) writes both at once; the four-word queue absorbs that.
// req_tready drops when the queue holds more than two words, so a stalled
// receiver backs up to the sender after at most four words.
// Reset clears the parser to wait for a start code and empties the queue.
// ----------------------------------------------------------------------------
module subtitle_pes_segment_deframer
   import spsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] buffer_first
   input  logic        req_tlast,   // buffer_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] seg_code, [23:8] page_id,
                                    // [39:24] seg_size, [47:40] payload_byte,
                                    // [48] segment_end, [51:49] status, zero above
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // run_last
);

   logic            accept;
   result_pair_type results;
   result_type      head;

   assign accept = req_tvalid && req_tready;

   spsd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_tdata),
      .buffer_first (req_tuser),
      .buffer_last  (req_tlast),
      .results      (results)
   );

   spsd_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (results),
      .has_room  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   assign rsp_tdata = {4'd0, head.status, head.segment_end, head.payload_byte,
                       head.seg_size, head.page_id, head.seg_code};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.run_last;

endmodule

// File: rtl/spsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsd_checker
// Port-level checks on the result channel of the deframer.
// ----------------------------------------------------------------------------
module spsd_checker
   import spsd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_HEADER || rsp_tuser == KIND_PAYLOAD ||
                      rsp_tuser == KIND_STATUS))
      else $error("undefined result kind");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_STATUS |-> rsp_tlast && rsp_tdata[48:0] == '0)
      else $error("status word not last or carries segment fields");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_STATUS |-> rsp_tdata[55:49] == '0)
      else $error("segment word carries a status");

endmodule

bind subtitle_pes_segment_deframer spsd_checker u_spsd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: bench/subtitle_pes_segment_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtitle_pes_segment_deframer_tb
// Feeds buffers of subtitle PES packets into the deframer: a directed pass
// over each packet shape (well formed and every error kind), then random
// packets, mostly well formed, with broken ones and noise mixed in. Words
// taken on the input are parsed by a behavioral parser in the bench, and
// every result word is checked field by field against the oldest predicted
// word. The sender runs in bursts with gaps, and the receiver stalls on its
// own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module subtitle_pes_segment_deframer_tb;
   import spsd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int ITEM_COUNT   = 1550;

   // packet shapes
   localparam int PKT_END_MARKER    = 0;
   localparam int PKT_EXACT         = 1;
   localparam int PKT_NOISE         = 2;
   localparam int PKT_BAD_START     = 3;
   localparam int PKT_BAD_STREAM    = 4;
   localparam int PKT_PES_SHORT     = 5;
   localparam int PKT_PAYLOAD_SHORT = 6;
   localparam int PKT_BAD_DATA_ID   = 7;
   localparam int PKT_BAD_SUBSTREAM = 8;
   localparam int PKT_BAD_MARKER    = 9;
   localparam int PKT_SEG_TRUNC     = 10;
   localparam int PKT_SEG_LONG      = 11;
   localparam int PKT_BUF_END       = 12;
   localparam int PKT_BUF_CUT       = 13;

   typedef struct {
      logic [7:0] data;
      logic       first;
      logic       last;
      bit         hold;   // wait for all results before offering
   } stream_byte_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   stream_byte_type pending_bytes[$];
   stream_byte_type next_byte;
   logic [7:0]   cur_buffer[$];
   bit           hold_next;
   result_type   expected_words[$];
   result_type   byte_words[$];
   result_type   want_word;

   int error_count;
   int words_seen;
   int accepted_count;
   int cycle_count;
   int burst_left;
   int gap_left;
   int hold_left;
   int mode_left;
   int rx_mode;
   bit long_hold_done;

   // parser state
   phase_type   parse_phase;
   logic [7:0]  field_count;
   logic [15:0] pes_len;
   logic [16:0] payload_left;
   logic [15:0] segment_left;
   logic [7:0]  seg_type;
   logic [15:0] seg_page;
   logic [15:0] seg_len;
   bit          dropping;

   subtitle_pes_segment_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- parser
   task automatic emit_word(input logic [1:0] kind, input bit seg, input logic [7:0] pbyte,
                            input bit seg_end, input logic [2:0] st);
      result_type w;
      w.kind           = kind;
      w.seg_code       = seg ? seg_type : 8'd0;
      w.page_id        = seg ? seg_page : 16'd0;
      w.seg_size       = seg ? seg_len : 16'd0;
      w.payload_byte   = pbyte;
      w.segment_end    = seg_end;
      w.status         = st;
      w.run_last       = 1'b0;
      byte_words.push_back(w);
   endtask

   // outcome known: report now if the packet ends here, else skip the rest
   task automatic close_packet(input logic [2:0] st);
      if (payload_left == 0) begin
         emit_word(KIND_STATUS, 0, 8'd0, 0, st);
         parse_phase = PH_SYNC0;
      end else begin
         field_count = {5'd0, st};
         parse_phase = PH_SKIP;
      end
   endtask

   task automatic drop_packet(input logic [2:0] st);
      emit_word(KIND_STATUS, 0, 8'd0, 0, st);
      parse_phase = PH_SYNC0;
      dropping = 1'b1;
   endtask

   task automatic enter_payload();
      if (payload_left <= 3) close_packet(ST_LENGTH);
      else parse_phase = PH_DATA_ID;
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic first, input logic last);
      result_type w;
      byte_words.delete();
      if (first) begin
         dropping = 1'b0;
         parse_phase = PH_SYNC0;
      end
      if (!dropping) begin
         case (parse_phase)
            PH_SYNC0: begin
               if (b != 8'h00) drop_packet(ST_PES_HEADER); else parse_phase = PH_SYNC1;
            end
            PH_SYNC1: begin
               if (b != 8'h00) drop_packet(ST_PES_HEADER); else parse_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
               if (b != START_CODE_LAST) drop_packet(ST_PES_HEADER);
               else parse_phase = PH_STREAM;
            end
            PH_STREAM: begin
               if (b != STREAM_ID_PRIVATE) drop_packet(ST_NOT_SUBT);
               else parse_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               pes_len = {b, 8'd0};
               parse_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               pes_len = pes_len | {8'd0, b};
               field_count = 8'd0;
               parse_phase = PH_FLAGS;
            end
            PH_FLAGS: begin
               field_count = field_count + 8'd1;
               if (field_count >= 2) parse_phase = PH_HLEN;
            end
            PH_HLEN: begin
               if (int'(pes_len) < int'(b) + 3) begin
                  drop_packet(ST_PES_HEADER);
               end else begin
                  payload_left = {1'b0, pes_len} - {9'd0, b} - 17'd3;
                  if (b > 0) begin
                     field_count = b;
                     parse_phase = PH_HEADER;
                  end else begin
                     enter_payload();
                  end
               end
            end
            PH_HEADER: begin
               field_count = field_count - 8'd1;
               if (field_count == 0) enter_payload();
            end
            PH_DATA_ID: begin
               payload_left = payload_left - 17'd1;
               if (b != DATA_IDENTIFIER) close_packet(ST_NOT_SUBT);
               else parse_phase = PH_SUBSTREAM;
            end
            PH_SUBSTREAM: begin
               payload_left = payload_left - 17'd1;
               if (b != 8'h00) close_packet(ST_NOT_SUBT); else parse_phase = PH_MARKER;
            end
            PH_MARKER: begin
               payload_left = payload_left - 17'd1;
               if (b == SEGMENT_SYNC) begin
                  if (payload_left < SEG_FIELD_BYTES) begin
                     close_packet(ST_LENGTH);
                  end else begin
                     field_count = 8'd0;
                     parse_phase = PH_SEG_FIELDS;
                  end
               end else begin
                  close_packet(b == END_MARKER ? ST_END_MARKER : ST_BAD_MARKER);
               end
            end
            PH_SEG_FIELDS: begin
               payload_left = payload_left - 17'd1;
               case (field_count)
                  8'd0: seg_type = b;
                  8'd1: seg_page = {b, 8'd0};
                  8'd2: seg_page = seg_page | {8'd0, b};
                  8'd3: seg_len = {b, 8'd0};
                  default: seg_len = seg_len | {8'd0, b};
               endcase
               field_count = field_count + 8'd1;
               if (field_count >= SEG_FIELD_BYTES) begin
                  if (payload_left < seg_len) begin
                     close_packet(ST_LENGTH);
                  end else begin
                     emit_word(KIND_HEADER, 1, 8'd0, 0, 3'd0);
                     segment_left = seg_len;
                     if (segment_left != 0) begin
                        parse_phase = PH_SEG_PAYLOAD;
                     end else if (payload_left == 0) begin
                        emit_word(KIND_STATUS, 0, 8'd0, 0, ST_NO_MARKER);
                        parse_phase = PH_SYNC0;
                     end else begin
                        parse_phase = PH_MARKER;
                     end
                  end
               end
            end
            PH_SEG_PAYLOAD: begin
               if (payload_left > 0) payload_left = payload_left - 17'd1;
               if (segment_left > 0) segment_left = segment_left - 16'd1;
               emit_word(KIND_PAYLOAD, 1, b, segment_left == 0, 3'd0);
               if (segment_left == 0) begin
                  if (payload_left == 0) begin
                     emit_word(KIND_STATUS, 0, 8'd0, 0, ST_NO_MARKER);
                     parse_phase = PH_SYNC0;
                  end else begin
                     parse_phase = PH_MARKER;
                  end
               end
            end
            PH_SKIP: begin
               if (payload_left > 0) payload_left = payload_left - 17'd1;
               if (payload_left == 0) begin
                  emit_word(KIND_STATUS, 0, 8'd0, 0, field_count[2:0]);
                  parse_phase = PH_SYNC0;
               end
            end
            default: parse_phase = PH_SYNC0;
         endcase
         if (last && !dropping && parse_phase != PH_SYNC0) drop_packet(ST_BUFFER_END);
      end
      if (byte_words.size() > 0) begin
         w = byte_words.pop_back();
         w.run_last = 1'b1;
         byte_words.push_back(w);
      end
      foreach (byte_words[i]) expected_words.push_back(byte_words[i]);
   endtask

   // -------------------------------------------------------------- stimulus
   task automatic push_byte(input logic [7:0] data, input logic first, input logic last);
      stream_byte_type s;
      s.data  = data;
      s.first = first;
      s.last  = last;
      s.hold  = hold_next;
      hold_next = 1'b0;
      pending_bytes.push_back(s);
   endtask

   task automatic flush_buffer(input bit with_last);
      foreach (cur_buffer[i])
         push_byte(cur_buffer[i], i == 0, with_last && i == cur_buffer.size() - 1);
      cur_buffer.delete();
   endtask

   task automatic add_noise();
      flush_buffer(1'b1);
      repeat ($urandom_range(1, 6))
         push_byte(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
   endtask

   task automatic add_packet(input int shape);
      logic [7:0]  pl[$];
      logic [7:0]  pk[$];
      int          hlen;
      int          nseg;
      int          slen;
      int          rest;
      int          cut;
      logic [15:0] plen;
      logic [7:0]  v;
      hlen = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
      pl.push_back(DATA_IDENTIFIER);
      pl.push_back(8'h00);
      nseg = $urandom_range(shape == PKT_EXACT ? 1 : 0, 3);
      repeat (nseg) begin
         slen = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
         pl.push_back(SEGMENT_SYNC);
         repeat (3) pl.push_back(8'($urandom));
         pl.push_back(8'(slen >> 8));
         pl.push_back(8'(slen));
         repeat (slen) pl.push_back(8'($urandom));
      end
      case (shape)
         PKT_END_MARKER, PKT_BAD_MARKER: begin
            v = 8'($urandom_range(0, 253));
            if (v >= SEGMENT_SYNC) v = v + 8'd1;
            pl.push_back(shape == PKT_END_MARKER ? END_MARKER : v);
            repeat ($urandom_range(0, 4)) pl.push_back(8'($urandom));
         end
         PKT_SEG_TRUNC: begin
            pl.push_back(SEGMENT_SYNC);
            repeat ($urandom_range(0, 4)) pl.push_back(8'($urandom));
         end
         PKT_SEG_LONG: begin
            rest = $urandom_range(0, 6);
            slen = $urandom_range(rest + 1, 65535);
            pl.push_back(SEGMENT_SYNC);
            repeat (3) pl.push_back(8'($urandom));
            pl.push_back(8'(slen >> 8));
            pl.push_back(8'(slen));
            repeat (rest) pl.push_back(8'($urandom));
         end
         PKT_BAD_DATA_ID: pl[0] = DATA_IDENTIFIER ^ 8'($urandom_range(1, 255));
         PKT_BAD_SUBSTREAM: pl[1] = 8'($urandom_range(1, 255));
         PKT_PAYLOAD_SHORT: begin
            pl.delete();
            repeat ($urandom_range(0, 3)) pl.push_back(8'($urandom));
         end
         default: ;
      endcase
      if (shape == PKT_PES_SHORT) begin
         hlen = $urandom_range(0, 255);
         plen = 16'($urandom_range(0, hlen + 2));
      end else begin
         plen = 16'(hlen + 3 + pl.size());
      end
      pk.push_back(8'h00);
      pk.push_back(8'h00);
      pk.push_back(START_CODE_LAST);
      pk.push_back(STREAM_ID_PRIVATE);
      pk.push_back(plen[15:8]);
      pk.push_back(plen[7:0]);
      pk.push_back(8'($urandom));
      pk.push_back(8'($urandom));
      pk.push_back(8'(hlen));
      if (shape != PKT_PES_SHORT) begin
         repeat (hlen) pk.push_back(8'($urandom));
         foreach (pl[i]) pk.push_back(pl[i]);
      end
      case (shape)
         PKT_BAD_START: begin
            cut = $urandom_range(0, 2);
            pk[cut] = (cut == 2) ? (START_CODE_LAST ^ 8'($urandom_range(1, 255)))
                                 : 8'($urandom_range(1, 255));
            while (pk.size() > cut + 1) void'(pk.pop_back());
         end
         PKT_BAD_STREAM: begin
            pk[3] = STREAM_ID_PRIVATE ^ 8'($urandom_range(1, 255));
            while (pk.size() > 4) void'(pk.pop_back());
         end
         PKT_BUF_END, PKT_BUF_CUT: begin
            if ($urandom_range(0, 1) == 1) begin
               plen = 16'($urandom_range(plen, 65535));
               pk[4] = plen[15:8];
               pk[5] = plen[7:0];
            end
            cut = $urandom_range(1, pk.size() - 1);
            while (pk.size() > cut) void'(pk.pop_back());
         end
         default: ;
      endcase
      foreach (pk[i]) cur_buffer.push_back(pk[i]);
      if (shape == PKT_BAD_START || shape == PKT_BAD_STREAM || shape == PKT_PES_SHORT ||
          shape == PKT_BUF_END)
         flush_buffer(1'b1);
      else if (shape == PKT_BUF_CUT)
         flush_buffer(1'b0);
      else if ($urandom_range(0, 2) == 0)
         flush_buffer(1'b1);
   endtask

   // ---------------------------------------------------------------- sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid   <= 1'b0;
         parse_phase  = PH_SYNC0;
         field_count  = 8'd0;
         pes_len      = 16'd0;
         payload_left = 17'd0;
         segment_left = 16'd0;
         seg_type     = 8'd0;
         seg_page     = 16'd0;
         seg_len      = 16'd0;
         dropping     = 1'b0;
         burst_left   = 0;
         gap_left     = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_byte(req_tdata, req_tuser, req_tlast);
            accepted_count <= accepted_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                        : $urandom_range(1, 20);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0 &&
                         !(pending_bytes[0].hold && expected_words.size() > 0)) begin
               next_byte = pending_bytes.pop_front();
               req_tdata  <= next_byte.data;
               req_tuser  <= next_byte.first;
               req_tlast  <= next_byte.last;
               req_tvalid <= 1'b1;
               burst_left = burst_left - 1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------- receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         mode_left = 0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && accepted_count >= 400) begin
         long_hold_done = 1'b1;
         hold_left = 150;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 200);
         end else begin
            mode_left = mode_left - 1;
         end
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // --------------------------------------------------------------- checker
   task automatic report_mismatch(input string msg);
      error_count++;
      $display("mismatch at result word %0d: %s", words_seen, msg);
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("word with none expected");
         end else begin
            want_word = expected_words.pop_front();
            compare_field("kind", 16'(rsp_tuser), 16'(want_word.kind));
            compare_field("seg_code", 16'(rsp_tdata[7:0]), 16'(want_word.seg_code));
            compare_field("page_id", rsp_tdata[23:8], want_word.page_id);
            compare_field("seg_size", rsp_tdata[39:24], want_word.seg_size);
            compare_field("payload_byte", 16'(rsp_tdata[47:40]), 16'(want_word.payload_byte));
            compare_field("segment_end", 16'(rsp_tdata[48]), 16'(want_word.segment_end));
            compare_field("status", 16'(rsp_tdata[51:49]), 16'(want_word.status));
            compare_field("pad", 16'(rsp_tdata[55:52]), 16'd0);
            compare_field("run_last", 16'(rsp_tlast), 16'(want_word.run_last));
         end
         words_seen++;
      end
   end

   // ------------------------------------------------------------------ main
   initial begin
      int r;
      for (int shape = PKT_END_MARKER; shape <= PKT_BUF_CUT; shape++) begin
         if (shape == PKT_NOISE) add_noise();
         else add_packet(shape);
      end
      flush_buffer(1'b1);
      hold_next = 1'b1;
      while (pending_bytes.size() + cur_buffer.size() < ITEM_COUNT) begin
         if ($urandom_range(0, 299) == 0) hold_next = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 30) add_packet(PKT_END_MARKER);
         else if (r < 55) add_packet(PKT_EXACT);
         else if (r < 59) add_noise();
         else add_packet($urandom_range(PKT_BAD_START, PKT_BUF_CUT));
      end
      flush_buffer(1'b1);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (pending_bytes.size() != 0 || req_tvalid || expected_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0)
         $display("subtitle_pes_segment_deframer_tb: clean");
      else
         $display("subtitle_pes_segment_deframer_tb: errors");
      $finish;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("subtitle_pes_segment_deframer_tb: errors");
      $finish;
   end

endmodule

// File: sim.f
rtl/spsd_pkg.sv
rtl/spsd_parser.sv
rtl/spsd_result_queue.sv
rtl/subtitle_pes_segment_deframer.sv
rtl/spsd_checker.sv
bench/subtitle_pes_segment_deframer_tb.sv
